// File: rtl/ieel_pkg.sv
`default_nettype none

package ieel_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned COUNT_W = 7;

    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic [INDEX_W-1:0]        index;
        logic signed [DATA_W-1:0]  value;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0]        count;
        logic [1:0]                status;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       rd_issue;
        logic       shift_init;
        logic       shift_step;
        logic       ins_commit;
        logic       era_commit;
        logic       respond;
        logic       use_rdata;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       idx_lt_count;
        logic       idx_gt_count;
        logic       full;
        logic       shift_done;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/ieel_ram.sv
`default_nettype none

module ieel_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ieel_ctrl.sv
`default_nettype none

module ieel_ctrl
    import ieel_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.action)
                    ACT_READ: begin
                        if (i_stat.idx_lt_count) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ_WAIT;
                        end else begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = STS_RANGE;
                            n_state       = S_IDLE;
                        end
                    end
                    ACT_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = STS_FULL;
                            n_state       = S_IDLE;
                        end else if (i_stat.idx_gt_count) begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = STS_RANGE;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHIFT;
                        end
                    end
                    ACT_ERASE: begin
                        if (i_stat.idx_lt_count) begin
                            o_cmd.shift_init = 1'b1;
                            n_state          = S_SHIFT;
                        end else begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = STS_RANGE;
                            n_state       = S_IDLE;
                        end
                    end
                    default: begin
                        o_cmd.respond = 1'b1;
                        o_cmd.status  = STS_OK;
                        n_state       = S_IDLE;
                    end
                endcase
            end
            S_READ_WAIT: begin
                o_cmd.respond   = 1'b1;
                o_cmd.use_rdata = 1'b1;
                o_cmd.status    = STS_OK;
                n_state         = S_IDLE;
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    if (i_stat.action == ACT_INSERT) begin
                        o_cmd.ins_commit = 1'b1;
                    end else begin
                        o_cmd.era_commit = 1'b1;
                    end
                    o_cmd.respond = 1'b1;
                    o_cmd.status  = STS_OK;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ieel_datapath.sv
`default_nettype none

module ieel_datapath
    import ieel_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_beat i_item,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    output logic          o_done,
    output t_out_beat     o_result
);

    localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    t_in_beat          r_item;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [CNT_W-1:0]  r_left;
    logic              r_pend;
    logic              r_done;
    t_out_beat         r_result;

    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [ADDR_W-1:0] idx_addr;
    logic              going_up;
    logic              rd_more;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    assign idx_ext  = CMP_W'(r_item.index);
    assign cnt_ext  = CMP_W'(r_count);
    assign idx_addr = ADDR_W'(r_item.index);
    assign going_up = (r_item.action == ACT_INSERT);
    assign rd_more  = (r_left != '0);

    assign o_stat.action       = r_item.action;
    assign o_stat.idx_lt_count = (idx_ext < cnt_ext);
    assign o_stat.idx_gt_count = (idx_ext > cnt_ext);
    assign o_stat.full         = (r_count == CNT_W'(CAPACITY));
    assign o_stat.shift_done   = !rd_more && !r_pend;

    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_addr;
        if (i_cmd.rd_issue) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_addr;
        end else if (i_cmd.shift_step && rd_more) begin
            ram_rd_en = 1'b1;
        end
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_addr;
        ram_wr_data = ram_rd_data;
        if (i_cmd.ins_commit) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_addr;
            ram_wr_data = r_item.value;
        end else if (i_cmd.shift_step && r_pend) begin
            ram_wr_en = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins_commit) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.era_commit) begin
            n_count = r_count - 1'b1;
        end
    end

    ieel_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.shift_init) begin
            if (going_up) begin
                r_rd_addr <= ADDR_W'(r_count - 1'b1);
                r_wr_addr <= ADDR_W'(r_count);
            end else begin
                r_rd_addr <= ADDR_W'(cnt_ext - cnt_ext + idx_ext + 1'b1);
                r_wr_addr <= idx_addr;
            end
        end else if (i_cmd.shift_step) begin
            if (rd_more) begin
                r_rd_addr <= going_up ? r_rd_addr - 1'b1 : r_rd_addr + 1'b1;
            end
            if (r_pend) begin
                r_wr_addr <= going_up ? r_wr_addr - 1'b1 : r_wr_addr + 1'b1;
            end
        end
        if (i_cmd.respond) begin
            r_result.read_value <= i_cmd.use_rdata ? ram_rd_data : '0;
            r_result.count      <= COUNT_W'(n_count);
            r_result.status     <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.respond;
            if (i_cmd.shift_init) begin
                r_pend <= 1'b0;
                if (going_up) begin
                    r_left <= CNT_W'(cnt_ext - idx_ext);
                end else begin
                    r_left <= CNT_W'(cnt_ext - idx_ext - 1'b1);
                end
            end else if (i_cmd.shift_step) begin
                r_pend <= rd_more;
                if (rd_more) begin
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: rtl/indexed_insert_erase_list.sv
// channel  | direction | handshake               | beat
// ---------+-----------+-------------------------+------------
// item     | in        | start & !busy           | i_item
// result   | out       | o_done, one cycle pulse | o_result
//
// a read answers after decode and a ram read wait; an error or unused action 3
// answers from decode; insert and erase commit at once when nothing moves, else
// entries move one per cycle through the single write port of the cell ram
// busy is high from the cycle after acceptance until the result pulse
// synchronous active-low reset empties the list; cells need no clearing
// results cannot be stalled: o_done lasts one cycle
`default_nettype none

module indexed_insert_erase_list
    import ieel_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_beat  i_item,
    output logic           busy,
    output logic           o_done,
    output t_out_beat      o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ieel_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    ieel_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: tb/indexed_insert_erase_list_tb.sv
`default_nettype none

module indexed_insert_erase_list_tb
    import ieel_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 64;
    localparam int N_RANDOM = 800;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_script_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_beat  item_drv = '0;
    logic      busy;
    logic      o_done;
    t_out_beat result;

    // directed rows may carry a typed-in expectation for the beat on the bus
    logic      row_typed = 1'b0;
    t_out_beat row_want = '0;

    logic signed [DATA_W-1:0] list_cells [CAPACITY];
    int                       list_len = 0;
    t_out_beat                expected_results [$];
    t_script_row              script [$];
    int                       errors = 0;

    indexed_insert_erase_list #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (item_drv),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(result)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_out_beat apply_list_op(input t_in_beat b);
        t_out_beat r;
        int        j;
        r = '0;
        r.status = STS_OK;
        case (b.action)
            ACT_READ: begin
                if (int'(b.index) < list_len) begin
                    r.read_value = list_cells[b.index];
                end else begin
                    r.status = STS_RANGE;
                end
            end
            ACT_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = STS_FULL;
                end else if (int'(b.index) > list_len) begin
                    r.status = STS_RANGE;
                end else begin
                    for (j = list_len; j > int'(b.index); j--) begin
                        list_cells[j] = list_cells[j-1];
                    end
                    list_cells[b.index] = b.value;
                    list_len++;
                end
            end
            ACT_ERASE: begin
                if (int'(b.index) < list_len) begin
                    for (j = int'(b.index) + 1; j < list_len; j++) begin
                        list_cells[j-1] = list_cells[j];
                    end
                    list_len--;
                end else begin
                    r.status = STS_RANGE;
                end
            end
            default: ;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // results are compared before the new beat is predicted, both at the same edge
    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat pred;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: read_value %0d count %0d status %0d",
                                 result.read_value, result.count, result.status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (result.read_value !== want.read_value || result.count !== want.count
                        || result.status !== want.status) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: read_value %0d/%0d count %0d/%0d status %0d/%0d",
                                     want.read_value, result.read_value, want.count,
                                     result.count, want.status, result.status);
                        end
                    end
                end
            end
            if (start && !busy) begin
                pred = apply_list_op(item_drv);
                expected_results.push_back(row_typed ? row_want : pred);
            end
        end
    end

    task automatic add_row(input logic [1:0] act, input int idx, input logic [31:0] val,
                           input logic typed, input logic [31:0] rd, input int cnt,
                           input logic [1:0] sts);
        t_script_row r;
        r.beat.action = act;
        r.beat.index = idx[INDEX_W-1:0];
        r.beat.value = val;
        r.typed = typed;
        r.want.read_value = rd;
        r.want.count = cnt[COUNT_W-1:0];
        r.want.status = sts;
        script.push_back(r);
    endtask

    // entered right after the edge that took the previous beat
    task automatic send_beat(input t_in_beat b, input logic typed, input t_out_beat want,
                             input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        item_drv <= b;
        row_typed = typed;
        row_want = want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        t_in_beat b;
        int       k;
        int       roll;
        int       phase;
        int       top;
        int       gap;
        logic     burst;

        add_row(ACT_READ,   0,  32'd0,         1'b1, 32'd0,         0, STS_RANGE);
        add_row(ACT_ERASE,  0,  32'd0,         1'b1, 32'd0,         0, STS_RANGE);
        add_row(ACT_INSERT, 1,  32'd5,         1'b1, 32'd0,         0, STS_RANGE);
        add_row(ACT_INSERT, 63, 32'd1,         1'b1, 32'd0,         0, STS_RANGE);
        add_row(ACT_INSERT, 0,  32'h7fffffff,  1'b1, 32'd0,         1, STS_OK);
        add_row(ACT_INSERT, 0,  32'h80000000,  1'b1, 32'd0,         2, STS_OK);
        add_row(ACT_READ,   0,  32'hffffffff,  1'b1, 32'h80000000,  2, STS_OK);
        add_row(ACT_READ,   1,  32'd0,         1'b1, 32'h7fffffff,  2, STS_OK);
        add_row(ACT_READ,   2,  32'd0,         1'b1, 32'd0,         2, STS_RANGE);
        add_row(ACT_INSERT, 2,  32'hffffffff,  1'b1, 32'd0,         3, STS_OK);
        add_row(ACT_INSERT, 1,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_READ,   1,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_READ,   3,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_UNUSED, 63, 32'hffffffff,  1'b1, 32'd0,         4, STS_OK);
        add_row(ACT_ERASE,  3,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_ERASE,  0,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_READ,   0,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_READ,   63, 32'd0,         1'b1, 32'd0,         2, STS_RANGE);
        add_row(ACT_ERASE,  63, 32'd0,         1'b1, 32'd0,         2, STS_RANGE);
        add_row(ACT_ERASE,  1,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_ERASE,  0,  32'd0,         1'b0, 32'd0,         0, STS_OK);
        add_row(ACT_ERASE,  0,  32'd0,         1'b1, 32'd0,         0, STS_RANGE);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst = 1'b0;
        for (k = 0; k < script.size(); k++) begin
            gap = (k < 8) ? 0 : $urandom_range(0, 15);
            send_beat(script[k].beat, script[k].typed, script[k].want, gap);
        end

        // phases: grow to full, mixed, shrink to empty, mixed
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 40 == 0) begin
                burst = ($urandom_range(0, 2) == 0);
            end
            phase = (k / 100) % 4;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                b.action = ACT_UNUSED;
            end else if (phase == 0) begin
                b.action = (roll < 75) ? ACT_INSERT : (roll < 85) ? ACT_ERASE : ACT_READ;
            end else if (phase == 2) begin
                b.action = (roll < 75) ? ACT_ERASE : (roll < 85) ? ACT_INSERT : ACT_READ;
            end else begin
                b.action = (roll < 35) ? ACT_INSERT : (roll < 65) ? ACT_ERASE : ACT_READ;
            end
            top = (b.action == ACT_INSERT) ? list_len : list_len - 1;
            if (top < 0) top = 0;
            if (top > CAPACITY - 1) top = CAPACITY - 1;
            if ($urandom_range(0, 4) == 0) begin
                b.index = INDEX_W'($urandom_range(0, CAPACITY - 1));
            end else begin
                b.index = INDEX_W'($urandom_range(0, top));
            end
            b.value = $urandom;
            gap = burst ? 0 : $urandom_range(0, 15);
            send_beat(b, 1'b0, '0, gap);
        end

        @(negedge i_clk);
        start <= 1'b0;
        row_typed = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("indexed_insert_erase_list_tb: clean");
        end else begin
            $display("indexed_insert_erase_list_tb: errors");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("indexed_insert_erase_list_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
